[rtl/flow_cache_with_timeouts_macros.svh]
// Assertion macros used by the checker in rtl/fc_checker.sv.
`ifndef FLOW_CACHE_WITH_TIMEOUTS_MACROS_SVH
`define FLOW_CACHE_WITH_TIMEOUTS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("flow cache assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("flow cache assertion failed");

`endif

[rtl/fc_pkg.sv]
`timescale 1ns / 1ps
package fc_pkg;
	localparam int CACHE_SLOTS = 64;
	localparam int SLOT_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
	localparam int CNT_W = $clog2(CACHE_SLOTS + 1);
	localparam int MAXF_W = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INACTIVE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FLOWS = 2'd2;

	localparam logic [31:0] ACTIVE_RESET = 32'(60 * 1000);
	localparam logic [31:0] INACTIVE_RESET = 32'(10 * 1000);
	localparam logic [MAXF_W-1:0] MAXF_RESET = MAXF_W'(CACHE_SLOTS);

	typedef enum logic [1:0] {
		CAUSE_ACTIVE   = 2'd0,
		CAUSE_INACTIVE = 2'd1,
		CAUSE_EVICT    = 2'd2,
		CAUSE_FLUSH    = 2'd3
	} cause_t;

	typedef enum logic {
		OP_PACKET = 1'b0,
		OP_FLUSH  = 1'b1
	} op_t;

	typedef struct packed {
		logic        cmd;
		logic [31:0] src_ip;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  protocol;
		logic [7:0]  tos;
		logic [15:0] octets;
		logic [31:0] time_ms;
	} fc_pkt_t;

	typedef struct packed {
		logic [31:0] rec_src_addr;
		logic [31:0] rec_dst_addr;
		logic [15:0] rec_src_port;
		logic [15:0] rec_dst_port;
		logic [7:0]  rec_protocol;
		logic [7:0]  rec_tos;
		logic [31:0] rec_packets;
		logic [31:0] rec_octets;
		logic [31:0] rec_first_ms;
		logic [31:0] rec_last_ms;
		logic [1:0]  export_cause;
		logic        last_record;
	} fc_rec_t;

	typedef struct packed {
		op_t     op;
		fc_pkt_t pkt;
	} fc_job_t;

	typedef struct packed {
		logic [31:0] src_ip;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  protocol;
		logic [7:0]  tos;
		logic [31:0] packets;
		logic [31:0] octets;
		logic [31:0] first_ms;
		logic [31:0] last_ms;
	} fc_entry_t;

	localparam int ENTRY_W = $bits(fc_entry_t);
endpackage

[rtl/fc_ifs.sv]
`timescale 1ns / 1ps
interface fc_in_if import fc_pkg::*;;
	logic    valid;
	logic    ready;
	fc_pkt_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface fc_out_if import fc_pkg::*;;
	logic    valid;
	logic    ready;
	fc_rec_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/fc_ram.sv]
`timescale 1ns / 1ps
module fc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[rtl/fc_front.sv]
`timescale 1ns / 1ps
module fc_front import fc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	fc_in_if.sink   pkt,
	output logic    q_valid,
	output fc_job_t q_job,
	input  logic    q_pop
);
	fc_job_t            buf_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               push;
	logic               pop;
	fc_job_t            job;

	assign pkt.ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign push = pkt.valid && pkt.ready;
	assign q_valid = (cnt_q != '0);
	assign pop = q_pop && q_valid;
	assign q_job = buf_q[rd_ptr_q];

	always_comb begin
		job.pkt = pkt.data;
		job.op = pkt.data.cmd ? OP_FLUSH : OP_PACKET;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

[rtl/fc_engine.sv]
`timescale 1ns / 1ps
module fc_engine import fc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  fc_job_t               q_job,
	output logic                  q_pop,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	fc_out_if.source              rec
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_EVICT,
		S_INSERT,
		S_FIN
	} state_t;

	state_t              state_q;
	fc_job_t             cur_q;
	logic [31:0]         act_q;
	logic [31:0]         inact_q;
	logic [MAXF_W-1:0]   maxf_q;
	logic [CACHE_SLOTS-1:0] valid_q;
	logic [CNT_W-1:0]    rd_cnt_q;
	logic                ev_v_s1;
	logic [SLOT_W-1:0]   ev_idx_s1;
	logic [CNT_W-1:0]    used_q;
	logic                hit_f_q;
	logic [SLOT_W-1:0]   hit_idx_q;
	fc_entry_t           hit_ent_q;
	logic                old_f_q;
	logic [SLOT_W-1:0]   old_idx_q;
	fc_entry_t           old_ent_q;
	logic                free_f_q;
	logic [SLOT_W-1:0]   free_idx_q;
	logic                out_v_q;
	fc_rec_t             out_q;
	logic                pend_v_q;
	fc_entry_t           pend_ent_q;
	cause_t              pend_cause_q;

	logic [ENTRY_W-1:0]  ram_rdata;
	fc_entry_t           rd_ent;
	logic                ram_re;
	logic                ram_we;
	logic [SLOT_W-1:0]   ram_waddr;
	fc_entry_t           ram_wdata;
	logic                is_flush;
	logic                ev_live;
	logic                ev_act;
	logic                ev_inact;
	logic                ev_emit;
	cause_t              ev_cause;
	logic                ev_match;
	logic                out_free;
	logic                can_emit;
	logic                emit_req;
	logic                emit_go;
	fc_entry_t           emit_ent;
	cause_t              emit_cause;
	logic                fin_go;
	logic                stall;
	logic                scan_end;
	logic [MAXF_W-1:0]   limit;
	fc_entry_t           hit_upd;
	fc_entry_t           new_ent;

	fc_ram #(.WIDTH(ENTRY_W), .DEPTH(CACHE_SLOTS)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(rd_cnt_q[SLOT_W-1:0]),
		.rdata(ram_rdata)
	);

	assign rd_ent = fc_entry_t'(ram_rdata);
	assign is_flush = (cur_q.op == OP_FLUSH);

	always_comb begin
		ev_live = ev_v_s1 && valid_q[ev_idx_s1];
		ev_act = (rd_ent.last_ms - rd_ent.first_ms) >= act_q;
		ev_inact = (cur_q.pkt.time_ms - rd_ent.last_ms) >= inact_q;
		ev_emit = ev_live && (is_flush || ev_act || ev_inact);
		if (is_flush) begin
			ev_cause = CAUSE_FLUSH;
		end else if (ev_act) begin
			ev_cause = CAUSE_ACTIVE;
		end else begin
			ev_cause = CAUSE_INACTIVE;
		end
		ev_match = (rd_ent.src_ip == cur_q.pkt.src_ip) &&
			(rd_ent.dst_addr == cur_q.pkt.dst_addr) &&
			(rd_ent.src_port == cur_q.pkt.src_port) &&
			(rd_ent.dst_port == cur_q.pkt.dst_port) &&
			(rd_ent.protocol == cur_q.pkt.protocol);
	end

	always_comb begin
		if (maxf_q == '0) begin
			limit = MAXF_W'(1);
		end else if (maxf_q > MAXF_W'(CACHE_SLOTS)) begin
			limit = MAXF_W'(CACHE_SLOTS);
		end else begin
			limit = maxf_q;
		end
	end

	assign out_free = !out_v_q || rec.ready;
	assign can_emit = !pend_v_q || out_free;

	always_comb begin
		emit_req = 1'b0;
		emit_ent = rd_ent;
		emit_cause = ev_cause;
		if (state_q == S_SCAN) begin
			emit_req = ev_emit;
		end else if (state_q == S_EVICT) begin
			emit_req = 1'b1;
			emit_ent = old_ent_q;
			emit_cause = CAUSE_EVICT;
		end
	end

	assign emit_go = emit_req && can_emit;
	assign stall = ev_emit && !can_emit;
	assign fin_go = (state_q == S_FIN) && pend_v_q && out_free;
	assign scan_end = (rd_cnt_q == CNT_W'(CACHE_SLOTS));
	assign ram_re = (state_q == S_SCAN) && !stall && !scan_end;
	assign q_pop = (state_q == S_IDLE) && q_valid;

	always_comb begin
		hit_upd = hit_ent_q;
		hit_upd.last_ms = cur_q.pkt.time_ms;
		hit_upd.packets = hit_ent_q.packets + 32'd1;
		hit_upd.octets = hit_ent_q.octets + 32'(cur_q.pkt.octets);
		new_ent.src_ip = cur_q.pkt.src_ip;
		new_ent.dst_addr = cur_q.pkt.dst_addr;
		new_ent.src_port = cur_q.pkt.src_port;
		new_ent.dst_port = cur_q.pkt.dst_port;
		new_ent.protocol = cur_q.pkt.protocol;
		new_ent.tos = cur_q.pkt.tos;
		new_ent.packets = 32'd1;
		new_ent.octets = 32'(cur_q.pkt.octets);
		new_ent.first_ms = cur_q.pkt.time_ms;
		new_ent.last_ms = cur_q.pkt.time_ms;
		ram_we = 1'b0;
		ram_waddr = free_idx_q;
		ram_wdata = new_ent;
		if (state_q == S_DECIDE && !is_flush && hit_f_q) begin
			ram_we = 1'b1;
			ram_waddr = hit_idx_q;
			ram_wdata = hit_upd;
		end else if (state_q == S_INSERT && free_f_q) begin
			ram_we = 1'b1;
		end
	end

	assign rec.valid = out_v_q;
	assign rec.data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q <= ACTIVE_RESET;
			inact_q <= INACTIVE_RESET;
			maxf_q <= MAXF_RESET;
			valid_q <= '0;
			rd_cnt_q <= '0;
			ev_v_s1 <= 1'b0;
			used_q <= '0;
			hit_f_q <= 1'b0;
			old_f_q <= 1'b0;
			free_f_q <= 1'b0;
			out_v_q <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_ACTIVE:    act_q <= cfg_data;
					REG_INACTIVE:  inact_q <= cfg_data;
					REG_MAX_FLOWS: maxf_q <= cfg_data[MAXF_W-1:0];
					default: ;
				endcase
			end

			if (emit_go) begin
				if (pend_v_q) begin
					out_q <= {pend_ent_q, pend_cause_q, 1'b0};
					out_v_q <= 1'b1;
				end else if (rec.valid && rec.ready) begin
					out_v_q <= 1'b0;
				end
				pend_ent_q <= emit_ent;
				pend_cause_q <= emit_cause;
				pend_v_q <= 1'b1;
			end else if (fin_go) begin
				out_q <= {pend_ent_q, pend_cause_q, 1'b1};
				out_v_q <= 1'b1;
				pend_v_q <= 1'b0;
			end else if (rec.valid && rec.ready) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cur_q <= q_job;
						rd_cnt_q <= '0;
						ev_v_s1 <= 1'b0;
						used_q <= '0;
						hit_f_q <= 1'b0;
						old_f_q <= 1'b0;
						free_f_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!stall) begin
						if (ev_v_s1) begin
							if (ev_emit) begin
								valid_q[ev_idx_s1] <= 1'b0;
							end
							if (!ev_live || ev_emit) begin
								if (!free_f_q) begin
									free_f_q <= 1'b1;
									free_idx_q <= ev_idx_s1;
								end
							end else begin
								used_q <= used_q + 1'b1;
								if (!hit_f_q && ev_match) begin
									hit_f_q <= 1'b1;
									hit_idx_q <= ev_idx_s1;
									hit_ent_q <= rd_ent;
								end
								if (!old_f_q || rd_ent.first_ms <= old_ent_q.first_ms) begin
									old_f_q <= 1'b1;
									old_idx_q <= ev_idx_s1;
									old_ent_q <= rd_ent;
								end
							end
						end
						if (scan_end) begin
							ev_v_s1 <= 1'b0;
							state_q <= S_DECIDE;
						end else begin
							ev_v_s1 <= 1'b1;
							ev_idx_s1 <= rd_cnt_q[SLOT_W-1:0];
							rd_cnt_q <= rd_cnt_q + 1'b1;
						end
					end
				end
				S_DECIDE: begin
					if (is_flush || hit_f_q) begin
						state_q <= S_FIN;
					end else if (MAXF_W'(used_q) >= limit && old_f_q) begin
						state_q <= S_EVICT;
					end else begin
						state_q <= S_INSERT;
					end
				end
				S_EVICT: begin
					if (can_emit) begin
						valid_q[old_idx_q] <= 1'b0;
						if (!free_f_q || old_idx_q < free_idx_q) begin
							free_f_q <= 1'b1;
							free_idx_q <= old_idx_q;
						end
						state_q <= S_INSERT;
					end
				end
				S_INSERT: begin
					if (free_f_q) begin
						valid_q[free_idx_q] <= 1'b1;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!pend_v_q || out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/flow_cache_with_timeouts.sv]
`timescale 1ns / 1ps
// Flow cache with active and inactive timeouts. Items arrive on pkt and are queued two deep;
// flow records leave on rec, one transfer per exported flow, with last_record set on the final
// record that an item causes. Each item walks every cache slot through the single read port
// of the entry memory, one slot per cycle except while a record waits for rec.ready.
// Configuration writes on cfg_we, cfg_idx and cfg_data are taken at any time but must only be
// issued while the block is idle.
module flow_cache_with_timeouts import fc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	fc_in_if.sink                 pkt,
	fc_out_if.source              rec,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	logic    q_valid;
	fc_job_t q_job;
	logic    q_pop;

	fc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt),
		.q_valid(q_valid),
		.q_job  (q_job),
		.q_pop  (q_pop)
	);

	fc_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_job   (q_job),
		.q_pop   (q_pop),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.rec     (rec)
	);
endmodule

[rtl/fc_checker.sv]
`timescale 1ns / 1ps
`include "flow_cache_with_timeouts_macros.svh"
module fc_checker import fc_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  rec_valid,
	input logic                  rec_ready,
	input fc_rec_t               rec_data,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_idx,
	input logic [CFG_DATA_W-1:0] cfg_data
);
	logic [31:0] act_q;
	logic [31:0] dur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= ACTIVE_RESET;
		end else if (cfg_we && cfg_idx == REG_ACTIVE) begin
			act_q <= cfg_data;
		end
	end

	assign dur = rec_data.rec_last_ms - rec_data.rec_first_ms;

	`FC_ASSERT_NEXT(a_rec_hold, clk, arst_n, rec_valid && !rec_ready, rec_valid)
	`FC_ASSERT_NOW(a_evict_last, clk, arst_n, rec_valid && rec_data.export_cause == CAUSE_EVICT, rec_data.last_record)
	`FC_ASSERT_NOW(a_active_dur, clk, arst_n, rec_valid && rec_data.export_cause == CAUSE_ACTIVE, dur >= act_q)
	`FC_ASSERT_NOW(a_inactive_dur, clk, arst_n, rec_valid && rec_data.export_cause == CAUSE_INACTIVE, dur < act_q)
endmodule

bind flow_cache_with_timeouts fc_checker u_fc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rec_valid(rec.valid),
	.rec_ready(rec.ready),
	.rec_data (rec.data),
	.cfg_we   (cfg_we),
	.cfg_idx  (cfg_idx),
	.cfg_data (cfg_data)
);

[sim/flow_checker.sv]
`timescale 1ns / 1ps
module flow_checker import fc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	fc_in_if                      pkt,
	fc_out_if                     rec,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending
);
	logic [31:0] active_ms;
	logic [31:0] idle_ms;
	logic [6:0]  flow_limit;
	bit          live[CACHE_SLOTS];
	fc_entry_t   slot[CACHE_SLOTS];
	fc_rec_t     due_exports[$];
	fc_rec_t     batch[$];

	function automatic void export_slot(int s, cause_t c);
		fc_rec_t r;
		r.rec_src_addr = slot[s].src_ip;
		r.rec_dst_addr = slot[s].dst_addr;
		r.rec_src_port = slot[s].src_port;
		r.rec_dst_port = slot[s].dst_port;
		r.rec_protocol = slot[s].protocol;
		r.rec_tos = slot[s].tos;
		r.rec_packets = slot[s].packets;
		r.rec_octets = slot[s].octets;
		r.rec_first_ms = slot[s].first_ms;
		r.rec_last_ms = slot[s].last_ms;
		r.export_cause = c;
		r.last_record = 1'b0;
		batch.push_back(r);
		live[s] = 0;
	endfunction

	function automatic void export_flows(fc_pkt_t p);
		int hit;
		int used;
		int lim;
		int oldest;
		int free_slot;
		hit = -1;
		used = 0;
		oldest = -1;
		free_slot = -1;
		batch.delete();
		if (p.cmd == OP_FLUSH) begin
			for (int s = 0; s < CACHE_SLOTS; s++)
				if (live[s])
					export_slot(s, CAUSE_FLUSH);
		end else begin
			lim = flow_limit;
			if (lim < 1)
				lim = 1;
			if (lim > CACHE_SLOTS)
				lim = CACHE_SLOTS;
			for (int s = 0; s < CACHE_SLOTS; s++) begin
				if (!live[s])
					continue;
				if (32'(slot[s].last_ms - slot[s].first_ms) >= active_ms)
					export_slot(s, CAUSE_ACTIVE);
				else if (32'(p.time_ms - slot[s].last_ms) >= idle_ms)
					export_slot(s, CAUSE_INACTIVE);
			end
			for (int s = 0; s < CACHE_SLOTS; s++) begin
				if (!live[s])
					continue;
				used++;
				if (hit < 0 && slot[s].src_ip == p.src_ip && slot[s].dst_addr == p.dst_addr
						&& slot[s].src_port == p.src_port && slot[s].dst_port == p.dst_port
						&& slot[s].protocol == p.protocol)
					hit = s;
			end
			if (hit >= 0) begin
				slot[hit].last_ms = p.time_ms;
				slot[hit].packets = slot[hit].packets + 32'd1;
				slot[hit].octets = slot[hit].octets + 32'(p.octets);
			end else begin
				if (used >= lim) begin
					for (int s = 0; s < CACHE_SLOTS; s++)
						if (live[s] && (oldest < 0 || slot[s].first_ms <= slot[oldest].first_ms))
							oldest = s;
					if (oldest >= 0)
						export_slot(oldest, CAUSE_EVICT);
				end
				for (int s = 0; s < CACHE_SLOTS; s++)
					if (!live[s] && free_slot < 0)
						free_slot = s;
				if (free_slot >= 0) begin
					live[free_slot] = 1;
					slot[free_slot].src_ip = p.src_ip;
					slot[free_slot].dst_addr = p.dst_addr;
					slot[free_slot].src_port = p.src_port;
					slot[free_slot].dst_port = p.dst_port;
					slot[free_slot].protocol = p.protocol;
					slot[free_slot].tos = p.tos;
					slot[free_slot].packets = 32'd1;
					slot[free_slot].octets = 32'(p.octets);
					slot[free_slot].first_ms = p.time_ms;
					slot[free_slot].last_ms = p.time_ms;
				end
			end
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].last_record = 1'b1;
		foreach (batch[k])
			due_exports.push_back(batch[k]);
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fc_rec_t want;
		fc_rec_t got;
		if (!arst_n) begin
			active_ms = ACTIVE_RESET;
			idle_ms = INACTIVE_RESET;
			flow_limit = MAXF_RESET;
			foreach (live[s])
				live[s] = 0;
			due_exports.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_ACTIVE: active_ms = cfg_data;
					REG_INACTIVE: idle_ms = cfg_data;
					REG_MAX_FLOWS: flow_limit = cfg_data[MAXF_W-1:0];
					default: ;
				endcase
			end
			if (pkt.valid && pkt.ready)
				export_flows(pkt.data);
			if (rec.valid && rec.ready) begin
				got = rec.data;
				if (due_exports.size() == 0) begin
					$error("unexpected flow record transfer: %0h", got);
					errors++;
				end else begin
					want = due_exports.pop_front();
					compare_field("rec_src_addr", want.rec_src_addr, got.rec_src_addr);
					compare_field("rec_dst_addr", want.rec_dst_addr, got.rec_dst_addr);
					compare_field("rec_src_port", want.rec_src_port, got.rec_src_port);
					compare_field("rec_dst_port", want.rec_dst_port, got.rec_dst_port);
					compare_field("rec_protocol", want.rec_protocol, got.rec_protocol);
					compare_field("rec_tos", want.rec_tos, got.rec_tos);
					compare_field("rec_packets", want.rec_packets, got.rec_packets);
					compare_field("rec_octets", want.rec_octets, got.rec_octets);
					compare_field("rec_first_ms", want.rec_first_ms, got.rec_first_ms);
					compare_field("rec_last_ms", want.rec_last_ms, got.rec_last_ms);
					compare_field("export_cause", want.export_cause, got.export_cause);
					compare_field("last_record", want.last_record, got.last_record);
				end
			end
		end
		pending = due_exports.size();
	end
endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
module testbench import fc_pkg::*;;
	typedef struct {
		logic [31:0] sa;
		logic [31:0] da;
		logic [15:0] sp;
		logic [15:0] dp;
		logic [7:0]  pr;
	} flow_key_t;

	localparam int NUM_KEYS = 72;
	localparam int QUIET_LIMIT = 4000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_cnt;
	int                    waiting_exports;
	int                    offered;
	int                    quiet;
	logic [31:0]           now_ms;
	flow_key_t             keys[NUM_KEYS];

	fc_in_if pkt_ch();
	fc_out_if rec_ch();

	flow_cache_with_timeouts uut (
		.clk(clk),
		.arst_n(arst_n),
		.pkt(pkt_ch),
		.rec(rec_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	flow_checker monitor (
		.clk(clk),
		.arst_n(arst_n),
		.pkt(pkt_ch),
		.rec(rec_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.errors(fail_cnt),
		.pending(waiting_exports)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic fc_pkt_t flow_pkt(int k, logic [31:0] t);
		fc_pkt_t p;
		p.cmd = OP_PACKET;
		p.src_ip = keys[k].sa;
		p.dst_addr = keys[k].da;
		p.src_port = keys[k].sp;
		p.dst_port = keys[k].dp;
		p.protocol = keys[k].pr;
		p.tos = 8'($urandom);
		p.octets = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
		p.time_ms = t;
		return p;
	endfunction

	function automatic fc_pkt_t random_pkt(op_t op);
		fc_pkt_t p;
		logic [223:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		p = raw[$bits(fc_pkt_t)-1:0];
		p.cmd = op;
		return p;
	endfunction

	task automatic push_item(fc_pkt_t d);
		int r;
		int gap;
		r = $urandom_range(0, 99);
		gap = (r < 70) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
		if (gap > 0) begin
			pkt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pkt_ch.valid <= 1'b1;
		pkt_ch.data <= d;
		do @(posedge clk); while (!pkt_ch.ready);
		offered++;
	endtask

	task automatic settle();
		pkt_ch.valid <= 1'b0;
		@(posedge clk);
		while (waiting_exports != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic set_regs(logic [31:0] act, logic [31:0] idle, logic [31:0] lim);
		cfg_we <= 1'b1;
		cfg_idx <= REG_ACTIVE;
		cfg_data <= act;
		@(posedge clk);
		cfg_idx <= REG_INACTIVE;
		cfg_data <= idle;
		@(posedge clk);
		cfg_idx <= REG_MAX_FLOWS;
		cfg_data <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(logic [31:0] act, logic [31:0] idle, logic [31:0] lim,
			int n, int pool, int step);
		int r;
		set_regs(act, idle, lim);
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 4)
				push_item(random_pkt(OP_FLUSH));
			else if (r < 12)
				push_item(random_pkt(OP_PACKET));
			else begin
				now_ms = now_ms + $urandom_range(0, step);
				push_item(flow_pkt($urandom_range(0, pool - 1), now_ms));
			end
		end
		settle();
	endtask

	initial begin
		logic [31:0] lim;
		arst_n = 0;
		cfg_we = 0;
		cfg_idx = REG_ACTIVE;
		cfg_data = '0;
		pkt_ch.valid = 0;
		pkt_ch.data = '0;
		offered = 0;
		now_ms = '0;
		foreach (keys[k])
			keys[k] = '{$urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom)};
		keys[0] = '{'0, '0, '0, '0, '0};
		keys[1] = '{'1, '1, '1, '1, '1};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_item(random_pkt(OP_FLUSH));
		push_item('{OP_PACKET, '0, '0, '0, '0, '0, '0, '0, 32'd5});
		push_item('{OP_PACKET, '1, '1, '1, '1, '1, '1, '1, 32'd5});
		push_item('{OP_PACKET, '1, '1, '1, '1, '1, '1, '1, 32'd100});
		push_item('{OP_PACKET, '1, '1, '1, '1, '1, '1, '1, 32'd200});
		for (int j = 0; j <= 9; j++)
			push_item(flow_pkt(2, 32'(20000 + 9000 * j)));
		push_item(random_pkt(OP_FLUSH));
		settle();

		now_ms = 32'hFFFF_FFF0;
		run_phase('0, '0, '0, 20, 4, 3);
		run_phase('1, '1, 32'h7F, 90, NUM_KEYS, 2);
		run_phase(32'd40, 32'd15, 32'hFFFF_FF80, 15, 4, 10);
		run_phase(32'd100000, 32'd100000, 32'd64, 25, 20, 5);
		run_phase(32'd100000, 32'd100000, 32'd3, 20, 24, 5);
		while (offered + 30 <= 310) begin
			if ($urandom_range(0, 4) == 0)
				now_ms = ($urandom_range(0, 1) == 0) ? $urandom : 32'hFFFF_FF00;
			lim = $urandom;
			lim[6:0] = ($urandom_range(0, 6) == 0) ? 7'd64 : 7'($urandom_range(1, 10));
			run_phase($urandom_range(5, 300), $urandom_range(3, 150), lim, 30,
				$urandom_range(2, 16), $urandom_range(0, 40));
		end

		if (fail_cnt == 0)
			$display("flow_cache_with_timeouts regression: pass");
		else
			$display("flow_cache_with_timeouts regression: fail");
		$finish;
	end

	initial begin
		bit pressed;
		int r;
		pressed = 0;
		rec_ch.ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (!pressed && offered >= 168) begin
				pressed = 1;
				rec_ch.ready <= 1'b0;
				repeat (500) @(posedge clk);
			end else if (r < 8) begin
				rec_ch.ready <= 1'b0;
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end else if (r < 14) begin
				rec_ch.ready <= 1'b1;
				repeat (300) @(posedge clk);
			end else begin
				repeat ($urandom_range(5, 30)) begin
					rec_ch.ready <= ($urandom_range(0, 3) != 0);
					@(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pkt_ch.valid && pkt_ch.ready) || (rec_ch.valid && rec_ch.ready))
			quiet <= 0;
		else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("flow_cache_with_timeouts regression: fail");
				$finish;
			end
		end
	end
endmodule
